/* sv/pid_pkg.sv */
// Shared types and constants for the priority interrupt dispatcher.
`timescale 1ns / 1ps
package pid_pkg;

   localparam int NUM_VECTORS_DEF = 64;
   localparam int VEC_W           = 6;
   localparam int VEC_SPACE       = 64;
   localparam int GROUP_SIZE      = 8;
   localparam int GROUP_W         = 3;
   localparam int WORD_W          = 16;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USER_W = 2;

   localparam logic [WORD_W-1:0] TABLE_BASE  = 16'hffc0;
   localparam logic [WORD_W-1:0] WORD_BYTES  = 16'd2;
   localparam logic [WORD_W-1:0] FRAME_BYTES = 16'd4;
   localparam logic [2:0]        RETI_OPCODE = 3'd6;

   typedef enum logic [1:0] {
      REQ_RAISE    = 2'd0,
      REQ_RETIRED  = 2'd1,
      REQ_DISPATCH = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_WRITE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic pick;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic in_dispatch;
   } dp_status_type;

endpackage

/* sv/pid_ctrl.sv */
// Sequencer: accepts one item, runs the vector search when needed, commits the result.
`timescale 1ns / 1ps
module pid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  pid_pkg::dp_status_type status,
   output pid_pkg::dp_cmd_type   cmd
);
   import pid_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.in_dispatch ? ST_PICK : ST_WRITE;
            end
         end
         ST_PICK: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
         end
         ST_WRITE: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/pid_datapath.sv */
// Pending set, in-service record, two-step priority search and result register.
`timescale 1ns / 1ps
module pid_datapath #(
   parameter int NUM_VECTORS = pid_pkg::NUM_VECTORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pid_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [pid_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic [pid_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [pid_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  pid_pkg::dp_cmd_type             cmd,
   output pid_pkg::dp_status_type          status
);
   import pid_pkg::*;

   function automatic logic [GROUP_W-1:0] highest8(input logic [GROUP_SIZE-1:0] bits);
      logic [GROUP_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         if (bits[i]) begin
            idx = GROUP_W'(i);
         end
      end
      return idx;
   endfunction

   // architectural state
   logic [NUM_VECTORS-1:0] pending_ff, pending_in;
   logic                   in_service_ff, in_service_in;
   logic [VEC_W-1:0]       svc_vec_ff, svc_vec_in;

   // latched item
   req_kind_type           kind_ff;
   logic [VEC_W-1:0]       vector_ff;
   logic                   fmt_one_ff;
   logic [2:0]             opcode_ff;
   logic [WORD_W-1:0]      cur_pc_ff, cur_sp_ff, cur_sr_ff;

   // search registers
   logic [GROUP_W-1:0]     group_ff;
   logic [VEC_W-1:0]       pick_vec_ff;

   // result register
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]  rsp_user_ff, rsp_user_in;

   logic [VEC_SPACE-1:0]   pending_wide;
   logic [GROUP_SIZE-1:0]  group_or;
   logic [GROUP_SIZE-1:0]  group_bits;
   logic [VEC_SPACE-1:0]   raise_onehot, pick_onehot;

   logic                   dispatched, finished, pending_any;
   logic [VEC_W-1:0]       disp_vec, fin_vec;
   logic [WORD_W-1:0]      pc_addr, pc_data, sr_addr, sr_data, new_sp, table_addr;

   assign status.in_dispatch = (req_kind_type'(req_tuser) == REQ_DISPATCH);

   assign pending_wide = VEC_SPACE'(pending_ff);

   always_comb begin
      for (int g = 0; g < GROUP_SIZE; g++) begin
         group_or[g] = |pending_wide[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   assign group_bits   = pending_wide[{group_ff, 3'b000} +: GROUP_SIZE];
   assign raise_onehot = VEC_SPACE'(1) << vector_ff;
   assign pick_onehot  = VEC_SPACE'(1) << pick_vec_ff;

   // effect of the latched item on state and result
   always_comb begin
      pending_in    = pending_ff;
      in_service_in = in_service_ff;
      svc_vec_in    = svc_vec_ff;
      dispatched    = 1'b0;
      finished      = 1'b0;
      disp_vec      = '0;
      fin_vec       = '0;
      pc_addr       = '0;
      pc_data       = '0;
      sr_addr       = '0;
      sr_data       = '0;
      new_sp        = '0;
      table_addr    = '0;
      case (kind_ff)
         REQ_RAISE: begin
            // vectors past the top of the set fall off the truncated one-hot
            pending_in = pending_ff | raise_onehot[NUM_VECTORS-1:0];
         end
         REQ_RETIRED: begin
            if (fmt_one_ff && opcode_ff == RETI_OPCODE && in_service_ff) begin
               finished      = 1'b1;
               fin_vec       = svc_vec_ff;
               in_service_in = 1'b0;
               svc_vec_in    = '0;
            end
         end
         REQ_DISPATCH: begin
            if ((|pending_ff) && !in_service_ff) begin
               dispatched    = 1'b1;
               disp_vec      = pick_vec_ff;
               pending_in    = pending_ff & ~pick_onehot[NUM_VECTORS-1:0];
               pc_addr       = cur_sp_ff - WORD_BYTES;
               pc_data       = cur_pc_ff;
               sr_addr       = cur_sp_ff - FRAME_BYTES;
               sr_data       = cur_sr_ff;
               new_sp        = cur_sp_ff - FRAME_BYTES;
               table_addr    = TABLE_BASE + WORD_W'(pick_vec_ff);
               in_service_in = 1'b1;
               svc_vec_in    = pick_vec_ff;
            end
         end
         REQ_CLEAR: begin
            pending_in = '0;
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
      pending_any = |pending_in;
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (cmd.commit) begin
         rsp_data_in = {3'b000, pending_any, table_addr, new_sp, sr_data, sr_addr,
                        pc_data, pc_addr, fin_vec, disp_vec};
         rsp_user_in = {finished, dispatched};
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         in_service_ff <= 1'b0;
         svc_vec_ff    <= '0;
      end else if (cmd.commit) begin
         pending_ff    <= pending_in;
         in_service_ff <= in_service_in;
         svc_vec_ff    <= svc_vec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind_type'(req_tuser);
         vector_ff  <= req_tdata[5:0];
         fmt_one_ff <= req_tdata[6];
         opcode_ff  <= req_tdata[9:7];
         cur_pc_ff  <= req_tdata[25:10];
         cur_sp_ff  <= req_tdata[41:26];
         cur_sr_ff  <= req_tdata[57:42];
         group_ff   <= highest8(group_or);
      end
      if (cmd.pick) begin
         pick_vec_ff <= {group_ff, highest8(group_bits)};
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

/* sv/priority_interrupt_dispatcher_unit.sv */
// Top level of the priority interrupt dispatcher: sequencer plus datapath.
`timescale 1ns / 1ps
// Tracks pending interrupt vectors and the one interrupt in service. Each item on the
// req_ stream is a raise, a retired instruction (RETI ends the interrupt in service), a
// dispatch attempt or a clear of all pending vectors; each item yields exactly one item on
// the rsp_ stream. A dispatch starts the highest pending vector when none is in service and
// returns the PC and SR stack pushes, the new SP and the vector-table address 0xffc0 plus
// the vector. The block handles one item at a time: raise, retire and clear items pass
// through ST_IDLE, which accepts and latches the item, and ST_WRITE, which loads the result
// into the output register once that register is free; dispatch items also pass through
// ST_PICK between them, the second step of the priority search (first the highest of eight
// groups of eight vectors, then the highest vector inside that group). A new item is taken
// as soon as the previous result is in the output register, even while that result still
// waits on rsp_tready.
module priority_interrupt_dispatcher_unit #(
   parameter int NUM_VECTORS = pid_pkg::NUM_VECTORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [5:0] vector, [6] instr_format_one, [9:7] instr_opcode, [25:10] cur_pc,
   // [41:26] cur_sp, [57:42] cur_sr, [63:58] zero
   input  logic [pid_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [pid_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [5:0] dispatch_vector, [11:6] finished_vector, [27:12] pc_push_addr,
   // [43:28] pc_push_data, [59:44] sr_push_addr, [75:60] sr_push_data,
   // [91:76] new_sp, [107:92] table_addr, [108] pending_any, [111:109] zero
   output logic [pid_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] dispatched, [1] finished
   output logic [pid_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import pid_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: accept, optional search step, commit into the output register
   pid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // state, priority search and result formatting
   pid_datapath #(
      .NUM_VECTORS (NUM_VECTORS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .cmd       (cmd),
      .status    (status)
   );

   // only one item in flight: the cycle after an accept takes no new item
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while one is in flight");

   // one result never both starts and ends an interrupt
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result both dispatched and finished");

   // a started vector always lies inside the configured set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> ({1'b0, rsp_tdata[5:0]} < 7'(NUM_VECTORS)))
      else $error("dispatched vector outside the vector set");

   // a command to load the output register only comes with a free output slot
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before it was taken");

endmodule
